### sv/bsfa_pkg.sv
// ----------------------------------------------------------------------------
// bsfa_pkg: shared types and constants of the banker safe fork allocator
// Unit count, field widths, status and action codes, word structs and the
// ring helpers that map a client to its two units.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfa_pkg;

   localparam int NUM_UNITS     = 5;
   localparam int NUM_NEED_REGS = 5;
   localparam int NUM_ROW_REGS  = (NUM_NEED_REGS < NUM_UNITS) ? NUM_NEED_REGS : NUM_UNITS;
   localparam int UNIT_IDX_W    = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int CLIENT_W      = 3;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 8;

   typedef enum logic [1:0] {
      STAT_GRANTED  = 2'd0,
      STAT_BUSY     = 2'd1,
      STAT_UNSAFE   = 2'd2,
      STAT_RELEASED = 2'd3
   } status_type;

   typedef enum logic {
      ACT_ACQUIRE = 1'b0,
      ACT_RELEASE = 1'b1
   } action_type;

   typedef struct packed {
      action_type          action;
      logic [CLIENT_W-1:0] client;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [CLIENT_W-1:0] first_unit;
      logic [CLIENT_W-1:0] second_unit;
   } rsp_type;

   // (p + 1) mod NUM_UNITS for any p that fits the client field
   function automatic logic [CLIENT_W-1:0] next_unit(input logic [CLIENT_W-1:0] p);
      logic [CLIENT_W:0] s;
      s = {1'b0, p} + (CLIENT_W+1)'(1);
      if (s >= (CLIENT_W+1)'(NUM_UNITS)) begin
         s = s - (CLIENT_W+1)'(NUM_UNITS);
      end
      return s[CLIENT_W-1:0];
   endfunction

   // mask of the client's own unit and the next unit around the ring
   function automatic logic [NUM_UNITS-1:0] pair_mask(input logic [CLIENT_W-1:0] p);
      logic [CLIENT_W-1:0]  nxt;
      logic [NUM_UNITS-1:0] m;
      nxt = next_unit(p);
      for (int u = 0; u < NUM_UNITS; u++) begin
         m[u] = (CLIENT_W'(u) == p) || (CLIENT_W'(u) == nxt);
      end
      return m;
   endfunction

endpackage

`default_nettype wire

### sv/banker_safe_fork_allocator_core.sv
// ----------------------------------------------------------------------------
// banker_safe_fork_allocator_core: ring fork allocator with safety check
// Client p asks for unit p and unit (p+1) mod NUM_UNITS. A release word, a
// busy acquire or an out-of-range client answers in the cycle after it is
// taken. An acquire whose two units are free is granted tentatively, then a
// banker's safety check walks the client rows one per cycle through a single
// shared row-compare unit: up to NUM_UNITS passes of NUM_UNITS rows (25 row
// checks at five units), stopping early once every row has finished; the
// verdict then waits in the hold state until the response register is free.
// A new word is taken only while the sequencer is idle and the response
// register is empty or being drained. The need rows come from csr writes that
// the user must make while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module banker_safe_fork_allocator_core (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire bsfa_pkg::req_type            req_data,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output bsfa_pkg::rsp_type                 rsp_data,
   input  wire                               csr_we,
   input  wire [bsfa_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire [bsfa_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CHECK = 3'b010,
      ST_HOLD  = 3'b100
   } state_type;

   localparam int N  = bsfa_pkg::NUM_UNITS;
   localparam int IW = bsfa_pkg::UNIT_IDX_W;
   localparam int CW = bsfa_pkg::CLIENT_W;

   state_type state_ff, state_in;

   // allocation state
   logic [N-1:0] free_ff, free_in;
   logic [N-1:0] hold_ff [N];
   logic [N-1:0] hold_in [N];
   logic [N-1:0] need_ff [N];
   logic [N-1:0] need_in [N];

   // safety-check sequencer
   logic [N-1:0]  work_ff, work_in;
   logic [N-1:0]  done_ff, done_in;
   logic [IW-1:0] pass_ff, pass_in;
   logic [IW-1:0] row_ff, row_in;
   logic [IW-1:0] cl_ff, cl_in;
   logic [N-1:0]  want_ff, want_in;
   bsfa_pkg::status_type pend_ff, pend_in;
   logic [CW-1:0] first_ff, first_in;
   logic [CW-1:0] second_ff, second_in;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   bsfa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic          slot_free;
   logic          req_acc;
   logic          in_range;
   logic [N-1:0]  req_want;
   logic [N-1:0]  give;
   logic [IW-1:0] req_cl;
   logic [N-1:0]  row_held;
   logic [N-1:0]  row_lack;
   logic          row_fits;
   logic          last_step;
   logic          check_end;
   logic          all_done;
   logic [N-1:0]  held_any;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && slot_free;
   assign req_acc   = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign in_range = {1'b0, req_data.client} < (CW+1)'(N);
   assign req_cl   = req_data.client[IW-1:0];
   assign req_want = bsfa_pkg::pair_mask(req_data.client);
   assign give     = req_want & hold_ff[req_cl];

   // shared row-compare unit: one client row per cycle
   assign row_held  = hold_ff[row_ff];
   assign row_lack  = need_ff[row_ff] & ~row_held;
   assign row_fits  = !done_ff[row_ff] && ((row_lack & ~work_ff) == '0);
   assign last_step = (pass_ff == IW'(N-1)) && (row_ff == IW'(N-1));

   always_comb begin
      state_in     = state_ff;
      free_in      = free_ff;
      hold_in      = hold_ff;
      need_in      = need_ff;
      work_in      = work_ff;
      done_in      = done_ff;
      pass_in      = pass_ff;
      row_in       = row_ff;
      cl_in        = cl_ff;
      want_in      = want_ff;
      pend_in      = pend_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      all_done     = 1'b0;
      check_end    = 1'b0;

      // need rows past the register list keep their reset value
      for (int r = 0; r < N; r++) begin
         if (csr_we && (r < bsfa_pkg::NUM_ROW_REGS) &&
             (csr_index == bsfa_pkg::CSR_INDEX_W'(r))) begin
            need_in[r] = csr_wdata[N-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               rsp_data_in.first_unit  = req_data.client;
               rsp_data_in.second_unit = bsfa_pkg::next_unit(req_data.client);
               first_in  = req_data.client;
               second_in = bsfa_pkg::next_unit(req_data.client);
               if (!in_range) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = (req_data.action == bsfa_pkg::ACT_RELEASE) ?
                                       bsfa_pkg::STAT_RELEASED : bsfa_pkg::STAT_BUSY;
               end else if (req_data.action == bsfa_pkg::ACT_RELEASE) begin
                  hold_in[req_cl]    = hold_ff[req_cl] & ~give;
                  free_in            = free_ff | give;
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = bsfa_pkg::STAT_RELEASED;
               end else if ((free_ff & req_want) != req_want) begin
                  rsp_valid_in       = 1'b1;
                  rsp_data_in.status = bsfa_pkg::STAT_BUSY;
               end else begin
                  // grant tentatively, then start the check from the new free mask
                  hold_in[req_cl] = hold_ff[req_cl] | req_want;
                  free_in         = free_ff & ~req_want;
                  work_in         = free_ff & ~req_want;
                  done_in         = '0;
                  pass_in         = '0;
                  row_in          = '0;
                  cl_in           = req_cl;
                  want_in         = req_want;
                  state_in        = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (row_fits) begin
               work_in         = work_ff | row_held;
               done_in[row_ff] = 1'b1;
            end
            all_done  = (done_in == {N{1'b1}});
            check_end = last_step || all_done;
            if (row_ff == IW'(N-1)) begin
               row_in  = '0;
               pass_in = pass_ff + IW'(1);
            end else begin
               row_in  = row_ff + IW'(1);
            end
            if (check_end) begin
               if (all_done) begin
                  pend_in = bsfa_pkg::STAT_GRANTED;
               end else begin
                  // unsafe: roll the tentative grant back
                  pend_in        = bsfa_pkg::STAT_UNSAFE;
                  hold_in[cl_ff] = hold_ff[cl_ff] & ~want_ff;
                  free_in        = free_ff | want_ff;
               end
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = pend_ff;
               rsp_data_in.first_unit  = first_ff;
               rsp_data_in.second_unit = second_ff;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= {N{1'b1}};
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < N; r++) begin
            hold_ff[r] <= '0;
            need_ff[r] <= bsfa_pkg::pair_mask(CW'(r));
         end
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
         hold_ff      <= hold_in;
         need_ff      <= need_in;
      end
   end

   // sequencer payload, no reset needed
   always_ff @(posedge clock) begin
      work_ff     <= work_in;
      done_ff     <= done_in;
      pass_ff     <= pass_in;
      row_ff      <= row_in;
      cl_ff       <= cl_in;
      want_ff     <= want_in;
      pend_ff     <= pend_in;
      first_ff    <= first_in;
      second_ff   <= second_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      held_any = '0;
      for (int r = 0; r < N; r++) begin
         held_any = held_any | hold_ff[r];
      end
   end

   // a unit is never both free and held
   a_free_held_disjoint: assert property (@(posedge clock) disable iff (reset)
      (free_ff & held_any) == '0)
      else $error("unit marked free while held");

   // only a checked acquire waits in the hold state
   a_hold_verdict: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_HOLD) |->
      (pend_ff == bsfa_pkg::STAT_GRANTED || pend_ff == bsfa_pkg::STAT_UNSAFE))
      else $error("hold state with a non-check verdict");

   // never take a word while a response would be overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      req_acc |-> slot_free)
      else $error("word taken while response slot is full");

   // finished rows stay finished across the check
   a_done_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CHECK && state_in == ST_CHECK) |=>
      ((done_ff & $past(done_ff)) == $past(done_ff)))
      else $error("finished row lost during safety check");

endmodule

`default_nettype wire

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for banker_safe_fork_allocator_core
// Drives acquire and release words for the ring clients and keeps a private
// copy of the free-unit mask, the holdings and the need rows. Every accepted
// request is turned into its expected reply, which must match the next reply
// the block hands out. The need rows are reloaded between phases while the
// block is idle. Both sides of the block see random bursts of backpressure.
// ----------------------------------------------------------------------------

module testbench;
   import bsfa_pkg::*;

   // Fork ledger: mirrors the allocator state and queues the replies that
   // each accepted request word must produce, oldest first.
   class fork_ledger;
      logic [CSR_DATA_W-1:0] need_rows [NUM_UNITS];
      logic [NUM_UNITS-1:0]  free_mask;
      logic [NUM_UNITS-1:0]  held [NUM_UNITS];
      rsp_type               replies_due [$];
      int                    faults;

      function new();
         faults    = 0;
         free_mask = '1;
         for (int c = 0; c < NUM_UNITS; c++) begin
            held[c]      = '0;
            need_rows[c] = CSR_DATA_W'(ring_pair(c));
         end
      endfunction

      // own unit plus the next one around the ring
      function logic [NUM_UNITS-1:0] ring_pair(int p);
         logic [NUM_UNITS-1:0] m;
         m = '0;
         m[p] = 1'b1;
         m[(p + 1) % NUM_UNITS] = 1'b1;
         return m;
      endfunction

      function void set_need(int index, logic [CSR_DATA_W-1:0] value);
         if (index < NUM_ROW_REGS) need_rows[index] = value;
      endfunction

      // banker's check: can every client still run to completion?
      function bit all_finish();
         logic [NUM_UNITS-1:0] work;
         logic [NUM_UNITS-1:0] done;
         logic [NUM_UNITS-1:0] lacking;
         work = free_mask;
         done = '0;
         for (int pass = 0; pass < NUM_UNITS; pass++) begin
            for (int c = 0; c < NUM_UNITS; c++) begin
               if (!done[c]) begin
                  lacking = need_rows[c][NUM_UNITS-1:0] & ~held[c];
                  if ((lacking & ~work) == '0) begin
                     work    = work | held[c];
                     done[c] = 1'b1;
                  end
               end
            end
         end
         return done == '1;
      endfunction

      function void note_request(req_type w);
         rsp_type              r;
         logic [NUM_UNITS-1:0] want;
         int                   c;
         c = int'(w.client);
         r.first_unit  = w.client;
         r.second_unit = CLIENT_W'((c + 1) % NUM_UNITS);
         if (c >= NUM_UNITS) begin
            r.status = (w.action == ACT_RELEASE) ? STAT_RELEASED : STAT_BUSY;
         end else if (w.action == ACT_ACQUIRE) begin
            want = ring_pair(c);
            if ((free_mask & want) != want) begin
               r.status = STAT_BUSY;
            end else begin
               free_mask = free_mask & ~want;
               held[c]   = held[c] | want;
               if (all_finish()) begin
                  r.status = STAT_GRANTED;
               end else begin
                  // roll the tentative grant back
                  held[c]   = held[c] & ~want;
                  free_mask = free_mask | want;
                  r.status  = STAT_UNSAFE;
               end
            end
         end else begin
            want      = ring_pair(c) & held[c];
            held[c]   = held[c] & ~want;
            free_mask = free_mask | want;
            r.status  = STAT_RELEASED;
         end
         replies_due.push_back(r);
      endfunction

      function void flag(string field, int due, int seen);
         faults++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, due, seen);
      endfunction

      function void check_reply(rsp_type got);
         rsp_type due;
         if (replies_due.size() == 0) begin
            faults++;
            $display("%0t: unexpected reply, expected none, actual status %0d units %0d/%0d",
                     $time, got.status, got.first_unit, got.second_unit);
            return;
         end
         due = replies_due.pop_front();
         if (got.status !== due.status) flag("status", due.status, got.status);
         if (got.first_unit !== due.first_unit)
            flag("first_unit", due.first_unit, got.first_unit);
         if (got.second_unit !== due.second_unit)
            flag("second_unit", due.second_unit, got.second_unit);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   fork_ledger ledger;
   int         gap_pct = 0;     // chance of a sender gap before a word
   int         stall_pct = 0;   // chance of a receiver stall burst
   int         stall_left = 0;

   banker_safe_fork_allocator_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs; the slowest legal run is far shorter.
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // Receiver: hold off rsp_ready in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready  <= 1'b0;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
         stall_left <= $urandom_range(12, 1) - 1;
         rsp_ready  <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: check replies first; a word taken at this edge cannot answer
   // at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) ledger.check_reply(rsp_data);
         if (req_valid && req_ready) ledger.note_request(req_data);
      end
   end

   function automatic req_type make_word(action_type a, int c);
      req_type w;
      w.action = a;
      w.client = CLIENT_W'(c);
      return w;
   endfunction

   // Mostly in-range clients; the rest are out-of-range noise.
   function automatic req_type random_word();
      int c;
      if (NUM_UNITS < 2**CLIENT_W && $urandom_range(99) >= 85)
         c = $urandom_range(2**CLIENT_W - 1, NUM_UNITS);
      else
         c = $urandom_range(NUM_UNITS - 1);
      return make_word($urandom_range(1) ? ACT_RELEASE : ACT_ACQUIRE, c);
   endfunction

   // Present one word, maybe after a gap, and hold it until it is taken.
   task automatic send_word(input req_type w);
      int gap;
      @(negedge clock);
      if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         gap = $urandom_range(12, 1);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait until every expected reply has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.replies_due.size() != 0) @(negedge clock);
   endtask

   // Reload the need rows while idle, plus one write past the register list.
   task automatic load_rows(input logic [CSR_DATA_W-1:0] rows [NUM_UNITS],
                            input int stray_index, input logic [CSR_DATA_W-1:0] stray_value);
      settle();
      for (int i = 0; i <= NUM_ROW_REGS; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'((i < NUM_ROW_REGS) ? i : stray_index);
         csr_wdata <= (i < NUM_ROW_REGS) ? rows[i] : stray_value;
         @(posedge clock);
         if (i < NUM_ROW_REGS) ledger.set_need(i, rows[i]);
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] rows [NUM_UNITS];
      ledger = new();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset need rows; all units start free.
      gap_pct   = 20;
      stall_pct = 20;
      send_word(make_word(ACT_ACQUIRE, 0));   // granted, units 0 and 1
      send_word(make_word(ACT_ACQUIRE, 0));   // busy: already holds them
      send_word(make_word(ACT_ACQUIRE, 1));   // busy: unit 1 taken
      send_word(make_word(ACT_ACQUIRE, 4));   // busy: unit 0 taken, wraps
      send_word(make_word(ACT_ACQUIRE, 2));   // granted, units 2 and 3
      send_word(make_word(ACT_RELEASE, 1));   // released, nothing held
      send_word(make_word(ACT_RELEASE, 0));
      send_word(make_word(ACT_ACQUIRE, 4));   // granted across the wrap
      send_word(make_word(ACT_RELEASE, 4));
      send_word(make_word(ACT_RELEASE, 2));
      send_word(make_word(ACT_ACQUIRE, 5));   // out of range: busy
      send_word(make_word(ACT_ACQUIRE, 7));
      send_word(make_word(ACT_RELEASE, 6));   // out of range: released
      send_word(make_word(ACT_RELEASE, 7));

      // Greedy rows for clients 0 and 2 make a second grant unsafe.
      rows = '{8'h1F, 8'd6, 8'hFF, 8'd24, 8'd17};
      load_rows(rows, 6, 8'h00);
      send_word(make_word(ACT_ACQUIRE, 0));   // granted
      send_word(make_word(ACT_ACQUIRE, 2));   // refused unsafe
      send_word(make_word(ACT_RELEASE, 0));

      // Random phases, each with its own need rows and backpressure mix.
      // The last one runs with no idling on either side.
      for (int ph = 1; ph <= 6; ph++) begin
         for (int i = 0; i < NUM_UNITS; i++) begin
            case (ph)
               1: rows[i] = 8'hFF;
               2: rows[i] = 8'h00;
               5: rows[i] = CSR_DATA_W'(ledger.ring_pair(i));
               default: rows[i] = CSR_DATA_W'($urandom_range(255));
            endcase
         end
         load_rows(rows, $urandom_range(2**CSR_INDEX_W - 1, NUM_ROW_REGS),
                   CSR_DATA_W'($urandom_range(255)));
         case (ph)
            1: begin gap_pct = 25; stall_pct = 25; end
            2: begin gap_pct = 0;  stall_pct = 40; end
            3: begin gap_pct = 40; stall_pct = 0;  end
            4: begin gap_pct = 15; stall_pct = 15; end
            5: begin gap_pct = 30; stall_pct = 30; end
            default: begin gap_pct = 0; stall_pct = 0; end
         endcase
         repeat (190) send_word(random_word());
      end

      // Drain, then give the block time to show any stray reply.
      settle();
      repeat (30) @(posedge clock);
      if (ledger.faults == 0 && ledger.replies_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
